>>> rtl/core/brc_pkg.sv
// Shared types and constants for the boolean relation composition block.
package brc_pkg;

    localparam int ROW_W      = 16;
    localparam int ROW_NUM_W  = 4;
    localparam int DIM_W      = 5;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_LEFT  = 2'd0,
        OP_LOAD_RIGHT = 2'd1,
        OP_COMPUTE    = 2'd2,
        OP_UNUSED     = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_ROW_COUNT     = 2'd0,
        CFG_INNER_DIMENSION    = 2'd1,
        CFG_RIGHT_COLUMN_COUNT = 2'd2,
        CFG_NONE               = 2'd3
    } cfg_index_t;

    typedef enum logic {
        STATUS_OK        = 1'b0,
        STATUS_EMPTY_DIM = 1'b1
    } status_t;

    typedef enum logic [1:0] {
        KIND_LOAD_LEFT  = 2'd0,
        KIND_LOAD_RIGHT = 2'd1,
        KIND_COMPUTE    = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [ROW_NUM_W-1:0]   row;
        logic [ROW_W-1:0]       data;
    } cmd_t;

    typedef struct packed {
        logic [DIM_W-1:0] row_count;
        logic [DIM_W-1:0] inner;
        logic [DIM_W-1:0] col_count;
    } dims_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

endpackage

>>> rtl/core/brc_front.sv
// Front end: configuration registers, request classification and queue push.
module brc_front #(
    parameter int MAX_DIM = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [brc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [brc_pkg::DIM_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [brc_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [brc_pkg::OP_W-1:0]        s_tuser,
    input  logic                            q_full,
    output logic                            q_push,
    output brc_pkg::cmd_t                   q_cmd,
    output brc_pkg::dims_t                  dims
);

    localparam int DIM_LIM = (MAX_DIM < brc_pkg::ROW_W) ? MAX_DIM : brc_pkg::ROW_W;
    localparam logic [brc_pkg::DIM_W-1:0] LIM = brc_pkg::DIM_W'(DIM_LIM);

    logic [brc_pkg::DIM_W-1:0] left_row_count_reg;
    logic [brc_pkg::DIM_W-1:0] inner_dimension_reg;
    logic [brc_pkg::DIM_W-1:0] right_column_count_reg;
    logic                      keep;
    brc_pkg::op_t              op;

    function automatic logic [brc_pkg::DIM_W-1:0] cap_dim(input logic [brc_pkg::DIM_W-1:0] v);
        return (v > LIM) ? LIM : v;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_row_count_reg     <= brc_pkg::DIM_RESET;
            inner_dimension_reg    <= brc_pkg::DIM_RESET;
            right_column_count_reg <= brc_pkg::DIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (brc_pkg::cfg_index_t'(cfg_index))
                brc_pkg::CFG_LEFT_ROW_COUNT:     left_row_count_reg     <= cfg_data;
                brc_pkg::CFG_INNER_DIMENSION:    inner_dimension_reg    <= cfg_data;
                brc_pkg::CFG_RIGHT_COLUMN_COUNT: right_column_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign dims.row_count = cap_dim(left_row_count_reg);
    assign dims.inner     = cap_dim(inner_dimension_reg);
    assign dims.col_count = cap_dim(right_column_count_reg);

    assign op       = brc_pkg::op_t'(s_tuser);
    assign s_tready = !q_full;

    always_comb begin
        q_cmd.row  = s_tdata[brc_pkg::ROW_NUM_W-1:0];
        q_cmd.data = s_tdata[brc_pkg::ROW_NUM_W +: brc_pkg::ROW_W];
        q_cmd.kind = brc_pkg::KIND_COMPUTE;
        keep       = 1'b0;
        case (op)
            brc_pkg::OP_LOAD_LEFT: begin
                q_cmd.kind = brc_pkg::KIND_LOAD_LEFT;
                keep       = {1'b0, q_cmd.row} < LIM;
            end
            brc_pkg::OP_LOAD_RIGHT: begin
                q_cmd.kind = brc_pkg::KIND_LOAD_RIGHT;
                keep       = {1'b0, q_cmd.row} < LIM;
            end
            brc_pkg::OP_COMPUTE: begin
                q_cmd.kind = brc_pkg::KIND_COMPUTE;
                keep       = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign q_push = s_tvalid && s_tready && keep;

endmodule

>>> rtl/core/brc_queue.sv
// Short request queue between the front end and the execution engine.
module brc_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  brc_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output brc_pkg::cmd_t head_cmd
);

    localparam int PTR_W = $clog2(brc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(brc_pkg::QUEUE_DEPTH + 1);

    brc_pkg::cmd_t     entry_mem [brc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(brc_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = entry_mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/core/brc_back.sv
// Execution engine: matrix storage, row product sequencer and output register.
module brc_back #(
    parameter int MAX_DIM = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  brc_pkg::dims_t                   dims,
    input  logic                             q_valid,
    input  brc_pkg::cmd_t                    q_cmd,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [brc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic [0:0]                       m_tuser,
    output logic                             m_tlast
);

    localparam int DIM_LIM = (MAX_DIM < brc_pkg::ROW_W) ? MAX_DIM : brc_pkg::ROW_W;
    localparam int IDX_W   = (DIM_LIM > 1) ? $clog2(DIM_LIM) : 1;
    localparam int PAD_W   = brc_pkg::OUT_TDATA_W - brc_pkg::ROW_NUM_W - brc_pkg::ROW_W;

    logic [brc_pkg::ROW_W-1:0]     left_mem  [DIM_LIM];
    logic [brc_pkg::ROW_W-1:0]     right_mem [DIM_LIM];

    brc_pkg::state_t               state_reg;
    brc_pkg::state_t               state_next;
    logic [brc_pkg::DIM_W-1:0]     row_cnt_reg;
    logic [brc_pkg::DIM_W-1:0]     row_cnt_next;

    logic                          out_valid_reg;
    logic [brc_pkg::ROW_NUM_W-1:0] out_row_reg;
    logic [brc_pkg::ROW_W-1:0]     out_data_reg;
    logic                          out_status_reg;
    logic                          out_last_reg;

    logic                          out_free;
    logic                          empty_dim;
    logic                          last_row;
    logic [brc_pkg::ROW_W-1:0]     left_row;
    logic [brc_pkg::ROW_W-1:0]     acc;
    logic [brc_pkg::ROW_W-1:0]     col_mask;

    logic                          wr_left;
    logic                          wr_right;
    logic                          emit;
    logic [brc_pkg::ROW_NUM_W-1:0] emit_row;
    logic [brc_pkg::ROW_W-1:0]     emit_data;
    brc_pkg::status_t              emit_status;
    logic                          emit_last;

    assign out_free  = !out_valid_reg || m_tready;
    assign empty_dim = (dims.row_count == '0) || (dims.inner == '0) ||
                       (dims.col_count == '0);
    assign last_row  = (row_cnt_reg + brc_pkg::DIM_W'(1)) == dims.row_count;
    assign left_row  = left_mem[row_cnt_reg[IDX_W-1:0]];

    always_comb begin
        acc = '0;
        for (int k = 0; k < DIM_LIM; k++) begin
            if (left_row[k] && (brc_pkg::DIM_W'(k) < dims.inner)) begin
                acc = acc | right_mem[k];
            end
        end
        for (int j = 0; j < brc_pkg::ROW_W; j++) begin
            col_mask[j] = brc_pkg::DIM_W'(j) < dims.col_count;
        end
    end

    always_comb begin
        state_next   = state_reg;
        row_cnt_next = row_cnt_reg;
        case (state_reg)
            brc_pkg::ST_IDLE: begin
                if (q_valid && (q_cmd.kind == brc_pkg::KIND_COMPUTE) && !empty_dim) begin
                    state_next   = brc_pkg::ST_RUN;
                    row_cnt_next = '0;
                end
            end
            brc_pkg::ST_RUN: begin
                if (out_free) begin
                    row_cnt_next = row_cnt_reg + brc_pkg::DIM_W'(1);
                    if (last_row) begin
                        state_next = brc_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = brc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop       = 1'b0;
        wr_left     = 1'b0;
        wr_right    = 1'b0;
        emit        = 1'b0;
        emit_row    = row_cnt_reg[brc_pkg::ROW_NUM_W-1:0];
        emit_data   = acc & col_mask;
        emit_status = brc_pkg::STATUS_OK;
        emit_last   = last_row;
        case (state_reg)
            brc_pkg::ST_IDLE: begin
                if (q_valid) begin
                    case (q_cmd.kind)
                        brc_pkg::KIND_LOAD_LEFT: begin
                            q_pop   = 1'b1;
                            wr_left = 1'b1;
                        end
                        brc_pkg::KIND_LOAD_RIGHT: begin
                            q_pop    = 1'b1;
                            wr_right = 1'b1;
                        end
                        brc_pkg::KIND_COMPUTE: begin
                            if (!empty_dim) begin
                                q_pop = 1'b1;
                            end else if (out_free) begin
                                q_pop       = 1'b1;
                                emit        = 1'b1;
                                emit_row    = '0;
                                emit_data   = '0;
                                emit_status = brc_pkg::STATUS_EMPTY_DIM;
                                emit_last   = 1'b1;
                            end
                        end
                        default: q_pop = 1'b1;
                    endcase
                end
            end
            brc_pkg::ST_RUN: begin
                emit = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_left) begin
            left_mem[q_cmd.row[IDX_W-1:0]] <= q_cmd.data;
        end
        if (wr_right) begin
            right_mem[q_cmd.row[IDX_W-1:0]] <= q_cmd.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= brc_pkg::ST_IDLE;
            row_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_row_reg    <= emit_row;
            out_data_reg   <= emit_data;
            out_status_reg <= emit_status;
            out_last_reg   <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_data_reg, out_row_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/core/boolean_relation_composition_top.sv
// Top level of the boolean relation composition block.
// Requests are accepted one per cycle while the four-entry request queue has room.
// A load is written at the edge that takes it from the queue.
// A product is popped into the run state and then gives one row per cycle while the output
// is not stalled, holding the engine until its last row; an error result is a single row.
// Reset clears queue, sequencer and output register and sets all dimensions to 16.
module boolean_relation_composition_top #(
    parameter int MAX_DIM = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [brc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [brc_pkg::DIM_W-1:0]        cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [3:0] row_number, [19:4] row_data, [23:20] zero
    input  logic [brc_pkg::IN_TDATA_W-1:0]   s_tdata,
    // [1:0] operation
    input  logic [brc_pkg::OP_W-1:0]         s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [3:0] product_row_number, [19:4] product_row_data, [23:20] zero
    output logic [brc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // [0] status
    output logic [0:0]                       m_tuser,
    output logic                             m_tlast
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_not_empty;
    brc_pkg::cmd_t  push_cmd;
    brc_pkg::cmd_t  head_cmd;
    brc_pkg::dims_t dims;

    brc_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd),
        .dims      (dims)
    );

    brc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    brc_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .dims     (dims),
        .q_valid  (q_not_empty),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/core/brc_checker.sv
// Port-level checker for the boolean relation composition block, with its bind.
module brc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [brc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic [0:0]                       m_tuser,
    input logic                             m_tlast
);

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
        $stable(m_tuser))
        else $error("stalled result changed");

    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == '0))
        else $error("error result is not a single empty last result");

    a_no_error_mid_product: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid || !m_tuser[0])
        else $error("error result inside a product");

endmodule

bind boolean_relation_composition_top brc_checker u_brc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> sim/brc_scoreboard.sv
// Scoreboard that predicts and checks product rows of the relation composition block.
module brc_scoreboard #(
    parameter int MAX_DIM = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [brc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [brc_pkg::DIM_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [brc_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [brc_pkg::OP_W-1:0]        s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [brc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic [0:0]                      m_tuser,
    input  logic                            m_tlast,
    output int                              mismatch_count,
    output int                              rows_outstanding,
    output int                              rows_checked
);

    typedef struct {
        logic [brc_pkg::ROW_NUM_W-1:0] row;
        logic [brc_pkg::ROW_W-1:0]     bits;
        brc_pkg::status_t              status;
        logic                          is_last;
    } product_row_t;

    logic [brc_pkg::DIM_W-1:0] row_count;
    logic [brc_pkg::DIM_W-1:0] inner;
    logic [brc_pkg::DIM_W-1:0] col_count;
    logic [brc_pkg::ROW_W-1:0] left_rows  [16];
    logic [brc_pkg::ROW_W-1:0] right_rows [16];
    product_row_t              product_rows_due [$];

    function automatic int capped(input logic [brc_pkg::DIM_W-1:0] v);
        int lim;
        lim = (MAX_DIM < brc_pkg::ROW_W) ? MAX_DIM : brc_pkg::ROW_W;
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
    endtask

    task automatic predict_product();
        int                        nr;
        int                        nk;
        int                        nc;
        logic [31:0]               col_mask;
        logic [brc_pkg::ROW_W-1:0] acc;
        product_row_t              p;
        nr = capped(row_count);
        nk = capped(inner);
        nc = capped(col_count);
        col_mask = (32'd1 << nc) - 32'd1;
        if (nr == 0 || nk == 0 || nc == 0) begin
            p.row     = '0;
            p.bits    = '0;
            p.status  = brc_pkg::STATUS_EMPTY_DIM;
            p.is_last = 1'b1;
            product_rows_due.insert(product_rows_due.size(), p);
        end else begin
            for (int i = 0; i < nr; i++) begin
                acc = '0;
                for (int k = 0; k < nk; k++) begin
                    if (left_rows[i][k]) begin
                        acc |= right_rows[k];
                    end
                end
                p.row     = brc_pkg::ROW_NUM_W'(i);
                p.bits    = acc & col_mask[brc_pkg::ROW_W-1:0];
                p.status  = brc_pkg::STATUS_OK;
                p.is_last = (i + 1 == nr);
                product_rows_due.insert(product_rows_due.size(), p);
            end
        end
    endtask

    always @(posedge aclk) begin
        product_row_t                  want;
        logic [brc_pkg::ROW_NUM_W-1:0] row_in;
        if (!aresetn) begin
            row_count      = brc_pkg::DIM_RESET;
            inner          = brc_pkg::DIM_RESET;
            col_count      = brc_pkg::DIM_RESET;
            mismatch_count = 0;
            rows_checked   = 0;
            for (int r = 0; r < 16; r++) begin
                left_rows[r]  = '0;
                right_rows[r] = '0;
            end
            product_rows_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    brc_pkg::CFG_LEFT_ROW_COUNT:     row_count = cfg_data;
                    brc_pkg::CFG_INNER_DIMENSION:    inner     = cfg_data;
                    brc_pkg::CFG_RIGHT_COLUMN_COUNT: col_count = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (product_rows_due.size() == 0) begin
                    report_mismatch("product row with none expected", 32'(m_tdata), 0);
                end else begin
                    want = product_rows_due.pop_front();
                    rows_checked++;
                    if (m_tdata[3:0] !== want.row)
                        report_mismatch("product_row_number", 32'(m_tdata[3:0]),
                                        32'(want.row));
                    if (m_tdata[19:4] !== want.bits)
                        report_mismatch("product_row_data", 32'(m_tdata[19:4]),
                                        32'(want.bits));
                    if (m_tdata[23:20] !== 4'h0)
                        report_mismatch("tdata padding", 32'(m_tdata[23:20]), 0);
                    if (m_tuser[0] !== want.status)
                        report_mismatch("status", 32'(m_tuser[0]), 32'(want.status));
                    if (m_tlast !== want.is_last)
                        report_mismatch("last", 32'(m_tlast), 32'(want.is_last));
                end
            end
            if (s_tvalid && s_tready) begin
                row_in = s_tdata[3:0];
                case (brc_pkg::op_t'(s_tuser))
                    brc_pkg::OP_LOAD_LEFT: begin
                        if (int'(row_in) < capped(5'd16)) left_rows[row_in] = s_tdata[19:4];
                    end
                    brc_pkg::OP_LOAD_RIGHT: begin
                        if (int'(row_in) < capped(5'd16)) right_rows[row_in] = s_tdata[19:4];
                    end
                    brc_pkg::OP_COMPUTE: predict_product();
                    default: ;
                endcase
            end
        end
        rows_outstanding = product_rows_due.size();
    end

endmodule

>>> sim/tb_top.sv
// Testbench top: drives requests and configuration, and reports the verdict.
module tb_top;

    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_CYCLES = 150;
    localparam int ITEMS_PER_PHASE = 18;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [brc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [brc_pkg::DIM_W-1:0]       cfg_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [brc_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic [brc_pkg::OP_W-1:0]        s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [brc_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]                      m_tuser;
    logic                            m_tlast;

    int   mismatch_count;
    int   rows_outstanding;
    int   rows_checked;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   stall_left = 0;
    logic stall_request = 1'b0;
    logic stall_done = 1'b0;
    int   n_loads = 0;
    int   n_computes = 0;
    int   n_unused = 0;
    int   n_settings = 0;

    logic [brc_pkg::DIM_W-1:0] phase_dims [0:8][0:2] = '{
        '{16, 16, 16}, '{1, 1, 1}, '{4, 9, 13}, '{31, 31, 31}, '{16, 1, 16},
        '{1, 16, 1}, '{16, 16, 16}, '{3, 0, 5}, '{0, 0, 0}
    };

    always #2 aclk = ~aclk;

    boolean_relation_composition_top #(.MAX_DIM(16)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    brc_scoreboard #(.MAX_DIM(16)) scoreboard (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast),
        .mismatch_count   (mismatch_count),
        .rows_outstanding (rows_outstanding),
        .rows_checked     (rows_checked)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d product rows outstanding",
                     cycle_count, rows_outstanding);
            $display("boolean_relation_composition_top verification failed");
            $finish;
        end
    end

    // The one long hold-off lets the request queue fill while the sender keeps offering.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (stall_request && !stall_done) begin
            stall_left <= STALL_CYCLES;
            stall_done <= 1'b1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_req(input brc_pkg::op_t op,
                            input logic [brc_pkg::ROW_NUM_W-1:0] row,
                            input logic [brc_pkg::ROW_W-1:0] bits);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'h0, bits, row};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        case (op)
            brc_pkg::OP_LOAD_LEFT, brc_pkg::OP_LOAD_RIGHT: n_loads++;
            brc_pkg::OP_COMPUTE:                           n_computes++;
            default:                                       n_unused++;
        endcase
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (rows_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input brc_pkg::cfg_index_t idx,
                             input logic [brc_pkg::DIM_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
    endtask

    task automatic set_dims(input logic [brc_pkg::DIM_W-1:0] rows,
                            input logic [brc_pkg::DIM_W-1:0] mid,
                            input logic [brc_pkg::DIM_W-1:0] cols);
        wait_idle();
        write_reg(brc_pkg::CFG_LEFT_ROW_COUNT, rows);
        write_reg(brc_pkg::CFG_INNER_DIMENSION, mid);
        write_reg(brc_pkg::CFG_RIGHT_COLUMN_COUNT, cols);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic random_req();
        int                        pick;
        brc_pkg::op_t              op;
        logic [brc_pkg::ROW_W-1:0] bits;
        pick = $urandom_range(99);
        if (pick < 38) op = brc_pkg::OP_LOAD_LEFT;
        else if (pick < 76) op = brc_pkg::OP_LOAD_RIGHT;
        else if (pick < 92) op = brc_pkg::OP_COMPUTE;
        else op = brc_pkg::OP_UNUSED;
        pick = $urandom_range(19);
        bits = (pick == 0) ? '0 : (pick < 3) ? '1 : brc_pkg::ROW_W'($urandom);
        send_req(op, brc_pkg::ROW_NUM_W'($urandom_range(15)), bits);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 20;
        recv_idle_pct <= 51;

        // Every row of both matrices is written before any product is requested.
        for (int r = 0; r < 16; r++) begin
            send_req(brc_pkg::OP_LOAD_LEFT, brc_pkg::ROW_NUM_W'(r),
                     brc_pkg::ROW_W'($urandom));
            send_req(brc_pkg::OP_LOAD_RIGHT, brc_pkg::ROW_NUM_W'(r),
                     brc_pkg::ROW_W'($urandom));
        end

        send_req(brc_pkg::OP_COMPUTE, '0, '0);
        send_req(brc_pkg::OP_LOAD_LEFT, 4'd0, 16'hFFFF);
        send_req(brc_pkg::OP_LOAD_LEFT, 4'd15, 16'h0000);
        send_req(brc_pkg::OP_LOAD_RIGHT, 4'd0, 16'h0001);
        send_req(brc_pkg::OP_LOAD_RIGHT, 4'd15, 16'hFFFF);
        send_req(brc_pkg::OP_LOAD_LEFT, 4'd7, 16'h8000);
        send_req(brc_pkg::OP_UNUSED, 4'd15, 16'hFFFF);
        send_req(brc_pkg::OP_COMPUTE, 4'd15, 16'hFFFF);
        wait_idle();
        write_reg(brc_pkg::CFG_NONE, '1);
        cfg_valid <= 1'b0;
        send_req(brc_pkg::OP_COMPUTE, '0, '0);
        set_dims(5'd0, 5'd16, 5'd16);
        send_req(brc_pkg::OP_COMPUTE, '0, '0);
        set_dims(5'd16, 5'd0, 5'd16);
        send_req(brc_pkg::OP_COMPUTE, '0, '0);
        set_dims(5'd16, 5'd16, 5'd0);
        send_req(brc_pkg::OP_COMPUTE, '0, '0);
        set_dims(5'd31, 5'd31, 5'd31);
        send_req(brc_pkg::OP_COMPUTE, '0, '0);
        set_dims(5'd17, 5'd1, 5'd1);
        send_req(brc_pkg::OP_COMPUTE, '0, '0);
        set_dims(5'd1, 5'd1, 5'd17);
        send_req(brc_pkg::OP_COMPUTE, '0, '0);

        phase_dims[8][0] = brc_pkg::DIM_W'($urandom_range(1, 16));
        phase_dims[8][1] = brc_pkg::DIM_W'($urandom_range(1, 16));
        phase_dims[8][2] = brc_pkg::DIM_W'($urandom_range(1, 16));
        for (int p = 0; p < 9; p++) begin
            set_dims(phase_dims[p][0], phase_dims[p][1], phase_dims[p][2]);
            if (p == 3) begin
                send_idle_pct = 51;
                recv_idle_pct <= 20;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
                stall_request <= 1'b1;
            end
            repeat (ITEMS_PER_PHASE) random_req();
        end

        wait_idle();
        $display("Sent %0d loads, %0d products and %0d unused requests over %0d settings.",
                 n_loads, n_computes, n_unused, n_settings);
        $display("Checked %0d product rows, %0d mismatches.", rows_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("boolean_relation_composition_top verification clean");
        end else begin
            $display("boolean_relation_composition_top verification failed");
        end
        $finish;
    end

endmodule
